/* sv/cbcm_pkg.sv */
// cbcm_pkg: shared constants, types and arithmetic helpers for the cbc byte cipher
// depends on nothing; used by the register block, the engine and the top-level core
`default_nettype none

package cbcm_pkg;

  localparam int MAX_BLOCK = 16;
  localparam int MODULUS   = 257;
  localparam int PW        = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int LW        = $clog2(MAX_BLOCK + 1);
  localparam int CFG_DW    = 64;
  localparam int CFG_AW    = 6;

  typedef enum logic [2:0] {
    REG_KEY_LOW   = 3'd0,
    REG_KEY_HIGH  = 3'd1,
    REG_IV_LOW    = 3'd2,
    REG_IV_HIGH   = 3'd3,
    REG_BLOCK_LEN = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [63:0]   key_low;
    logic [63:0]   key_high;
    logic [63:0]   iv_low;
    logic [63:0]   iv_high;
    logic [LW-1:0] eff_len;
    logic          iv_load;
  } cfg_t;

  typedef logic [255:0][7:0] inv_table_t;

  // byte i of the 128-bit pair, zero past the sixteenth byte
  function automatic logic [7:0] pick_byte(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [PW-1:0] i);
    logic [127:0] cat;
    cat = {hi, lo};
    return 8'(cat >> (8 * int'(i)));
  endfunction

  // ((a+1)*(b+1) mod 257) - 1, using 256 == -1 mod 257
  function automatic logic [7:0] mul257(input logic [7:0] a, input logic [7:0] b);
    logic [16:0] p;
    logic [9:0]  d;
    p = 17'({1'b0, a} + 9'd1) * 17'({1'b0, b} + 9'd1);
    d = {2'b00, p[7:0]} - {1'b0, p[16:8]};
    if (d[9]) begin
      d = d + 10'(MODULUS);
    end
    return 8'(d - 10'd1);
  endfunction

  // inverse of k+1 by fermat, stored minus one
  function automatic inv_table_t build_inv();
    inv_table_t t;
    int acc;
    int base;
    int e;
    for (int k = 0; k < 256; k++) begin
      acc  = 1;
      base = k + 1;
      e    = MODULUS - 2;
      for (int j = 0; j < 8; j++) begin
        if ((e & 1) != 0) begin
          acc = (acc * base) % MODULUS;
        end
        base = (base * base) % MODULUS;
        e    = e >> 1;
      end
      t[k] = 8'(acc - 1);
    end
    return t;
  endfunction

  localparam inv_table_t INV_TABLE = build_inv();

endpackage

`default_nettype wire

/* sv/cbcm_if.sv */
// cbcm_in_if and cbcm_out_if: valid/ready channels for byte requests and results
// no dependencies
`default_nettype none

interface cbcm_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface cbcm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;
  logic       block_end;

  modport source (output valid, output result_byte, output block_end, input ready);
  modport sink (input valid, input result_byte, input block_end, output ready);
endinterface

`default_nettype wire

/* sv/cbcm_regs.sv */
// cbcm_regs: apb register file for key, iv and block length
// depends on cbcm_pkg
`default_nettype none

module cbcm_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [cbcm_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [cbcm_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [cbcm_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready,
  output cbcm_pkg::cfg_t                  cfg
);
  import cbcm_pkg::*;

  logic [63:0] key_low_r, key_high_r, iv_low_r, iv_high_r;
  logic [4:0]  block_len_r;
  logic        wr_en;
  reg_idx_t    idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_AW-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r   <= '0;
      key_high_r  <= '0;
      iv_low_r    <= '0;
      iv_high_r   <= '0;
      block_len_r <= 5'd16;
    end else if (wr_en) begin
      case (idx)
        REG_KEY_LOW:   key_low_r   <= cfg_pwdata;
        REG_KEY_HIGH:  key_high_r  <= cfg_pwdata;
        REG_IV_LOW:    iv_low_r    <= cfg_pwdata;
        REG_IV_HIGH:   iv_high_r   <= cfg_pwdata;
        REG_BLOCK_LEN: block_len_r <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KEY_LOW:   cfg_prdata = key_low_r;
      REG_KEY_HIGH:  cfg_prdata = key_high_r;
      REG_IV_LOW:    cfg_prdata = iv_low_r;
      REG_IV_HIGH:   cfg_prdata = iv_high_r;
      REG_BLOCK_LEN: cfg_prdata = {59'd0, block_len_r};
      default:       cfg_prdata = '0;
    endcase
  end

  always_comb begin
    cfg.key_low  = key_low_r;
    cfg.key_high = key_high_r;
    // the new iv shows at the same edge the engine drops its chain state
    cfg.iv_low   = iv_low_r;
    cfg.iv_high  = iv_high_r;
    cfg.iv_load  = wr_en && (idx == REG_IV_LOW || idx == REG_IV_HIGH);
    if (block_len_r == 5'd0) begin
      cfg.eff_len = LW'(1);
    end else if (int'(block_len_r) > MAX_BLOCK) begin
      cfg.eff_len = LW'(MAX_BLOCK);
    end else begin
      cfg.eff_len = LW'(block_len_r);
    end
  end

endmodule

`default_nettype wire

/* sv/cbcm_engine.sv */
// cbcm_engine: chain memories, positions and the two-stage multiply mod 257 pipeline
// depends on cbcm_pkg and the channel interfaces in cbcm_if
`default_nettype none

module cbcm_engine (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cbcm_pkg::cfg_t cfg,
  cbcm_in_if.sink       in_ch,
  cbcm_out_if.source    out_ch
);
  import cbcm_pkg::*;

  logic [7:0] enc_mem [MAX_BLOCK];
  logic [7:0] dec_mem [MAX_BLOCK];

  logic [PW-1:0]        enc_pos_r, dec_pos_r, pos;
  logic [MAX_BLOCK-1:0] enc_vld_r, dec_vld_r;
  logic [LW-1:0]        pos_inc;
  logic                 acc, last, s1_adv;
  logic [7:0]           kb, kop;

  logic          s1_vld_r, s1_dir_r, s1_last_r, s1_cv_r;
  logic [PW-1:0] s1_pos_r;
  logic [7:0]    s1_k_r, s1_data_r, enc_rd_r, dec_rd_r;

  logic          enc_fv_r, dec_fv_r;
  logic [PW-1:0] enc_fa_r, dec_fa_r;
  logic [7:0]    enc_fd_r, dec_fd_r;

  logic       out_vld_r, out_end_r;
  logic [7:0] out_res_r;

  logic [7:0] iv_byte, chain_e, chain_d, mul_a, prod, res;

  // stage 0: position, key byte and multiplier operand
  assign acc     = in_ch.valid && in_ch.ready;
  assign pos     = in_ch.func ? dec_pos_r : enc_pos_r;
  assign pos_inc = LW'(pos) + LW'(1);
  assign last    = (pos_inc >= cfg.eff_len);
  assign kb      = pick_byte(cfg.key_low, cfg.key_high, pos);
  assign kop     = in_ch.func ? INV_TABLE[kb] : kb;

  assign s1_adv      = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_pos_r <= '0;
      dec_pos_r <= '0;
    end else if (cfg.iv_load) begin
      enc_pos_r <= '0;
      dec_pos_r <= '0;
    end else if (acc) begin
      if (in_ch.func) begin
        dec_pos_r <= last ? '0 : PW'(pos_inc);
      end else begin
        enc_pos_r <= last ? '0 : PW'(pos_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_dir_r  <= in_ch.func;
      s1_pos_r  <= pos;
      s1_k_r    <= kop;
      s1_data_r <= in_ch.data_byte;
      s1_last_r <= last;
      s1_cv_r   <= in_ch.func ? dec_vld_r[pos] : enc_vld_r[pos];
      enc_rd_r  <= enc_mem[pos];
      dec_rd_r  <= dec_mem[pos];
    end
  end

  // stage 1: chain byte with forwarding of the write from the edge of the read
  assign iv_byte = pick_byte(cfg.iv_low, cfg.iv_high, s1_pos_r);
  assign chain_e = (enc_fv_r && enc_fa_r == s1_pos_r) ? enc_fd_r :
                   (s1_cv_r ? enc_rd_r : iv_byte);
  assign chain_d = (dec_fv_r && dec_fa_r == s1_pos_r) ? dec_fd_r :
                   (s1_cv_r ? dec_rd_r : iv_byte);
  assign mul_a   = s1_dir_r ? s1_data_r : (s1_data_r ^ chain_e);
  assign prod    = mul257(mul_a, s1_k_r);
  assign res     = s1_dir_r ? (prod ^ chain_d) : prod;

  always_ff @(posedge clk) begin
    if (s1_adv && !s1_dir_r) begin
      enc_mem[s1_pos_r] <= res;
    end
    if (s1_adv && s1_dir_r) begin
      dec_mem[s1_pos_r] <= s1_data_r;
    end
    if (s1_adv) begin
      out_res_r <= res;
      out_end_r <= s1_last_r;
      if (s1_dir_r) begin
        dec_fa_r <= s1_pos_r;
        dec_fd_r <= s1_data_r;
      end else begin
        enc_fa_r <= s1_pos_r;
        enc_fd_r <= res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      enc_vld_r <= '0;
      dec_vld_r <= '0;
      enc_fv_r  <= 1'b0;
      dec_fv_r  <= 1'b0;
    end else begin
      if (acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      // entries not written since the last iv load read as the iv byte
      if (cfg.iv_load) begin
        enc_vld_r <= '0;
        dec_vld_r <= '0;
        enc_fv_r  <= 1'b0;
        dec_fv_r  <= 1'b0;
      end else if (s1_adv) begin
        if (s1_dir_r) begin
          dec_vld_r[s1_pos_r] <= 1'b1;
          dec_fv_r            <= 1'b1;
        end else begin
          enc_vld_r[s1_pos_r] <= 1'b1;
          enc_fv_r            <= 1'b1;
        end
      end
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.result_byte = out_res_r;
  assign out_ch.block_end   = out_end_r;

endmodule

`default_nettype wire

/* sv/cbc_byte_multiply_mod257_cipher_core.sv */
// cbc byte cipher core: one byte per request, multiply mod 257 with cbc chaining
// a byte passes the stage-one registers, then the output register
// throughput: one byte per cycle unless the output stalls, set by the chain
// memory read-modify-write, forwarding the previous write; output register decouples the sides
// reset: positions zero, chains read as the iv through per-entry valid bits,
// no clearing pass; block length resets to 16, key and iv to zero
`default_nettype none

module cbc_byte_multiply_mod257_cipher_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  cbcm_in_if.sink                         in_ch,
  cbcm_out_if.source                      out_ch,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [cbcm_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [cbcm_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [cbcm_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);
  import cbcm_pkg::*;

  cfg_t cfg;

  cbcm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  cbcm_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
